/* hdl/uclp_pkg.sv */
// ----------------------------------------------------------------------------
// uclp_pkg
// Shared types, character codes and result codes of the command line parser.
// ----------------------------------------------------------------------------
package uclp_pkg;

  localparam int LINE_W       = 8;
  localparam int MAX_LINE_DEF = 64;

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam int TOK_CHARS    = 5;
  localparam int TOK_LEN_W    = 3;
  localparam int NUM_W        = 32;
  localparam int ACC_W        = NUM_W + 4;

  // character codes
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_PLUS   = 8'd43;
  localparam logic [7:0] CH_MINUS  = 8'd45;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_VT     = 8'd11;
  localparam logic [7:0] CH_FF     = 8'd12;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;

  // keywords, first character in the top byte
  localparam logic [31:0] KW_GET  = "$GET";
  localparam logic [31:0] KW_PUT  = "$PUT";
  localparam logic [31:0] KW_TEMP = "TEMP";
  localparam logic [15:0] KW_PH   = "PH";
  localparam logic [23:0] KW_LED  = "LED";

  // result codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CMD  = 2'd1;
  localparam logic [1:0] ST_BAD_DEV  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [1:0] DEV_TEMP = 2'd0;
  localparam logic [1:0] DEV_PH   = 2'd1;
  localparam logic [1:0] DEV_LED  = 2'd2;

  // token index within a line
  localparam logic [1:0] TOK_CMD   = 2'd0;
  localparam logic [1:0] TOK_DEV   = 2'd1;
  localparam logic [1:0] TOK_PARAM = 2'd2;
  localparam logic [1:0] TOK_PAST  = 2'd3;

  localparam logic [NUM_W-1:0] NUM_SAT = 32'h8000_0000;
  localparam logic [NUM_W-1:0] NUM_MAX = 32'h7fff_ffff;

  typedef enum logic [1:0] {
    NUM_IDLE,
    NUM_DIGITS,
    NUM_STOP
  } num_phase_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       nl;
    logic       space;
    logic       dollar;
    logic       digit;
    logic       blank;
    logic       plus;
    logic       minus;
    logic       first;
    logic       over;
  } rx_word_t;

endpackage

/* hdl/uclp_if.sv */
// ----------------------------------------------------------------------------
// uclp_if
// Valid/ready channels of the parser: received bytes in, parsed lines out.
// ----------------------------------------------------------------------------
interface uclp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface uclp_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               command;
  logic [1:0]         device;
  logic               param_present;
  logic signed [31:0] param_value;

  modport source (output valid, output status, output command, output device,
                  output param_present, output param_value, input ready);
  modport sink   (input valid, input status, input command, input device,
                  input param_present, input param_value, output ready);
endinterface

/* hdl/uclp_front.sv */
// ----------------------------------------------------------------------------
// uclp_front
// Accepts bytes, tracks the position in the line and classifies each byte.
// ----------------------------------------------------------------------------
module uclp_front #(
  parameter int MAX_LINE = uclp_pkg::MAX_LINE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  uclp_byte_if.sink         rx,
  output logic              push,
  output uclp_pkg::rx_word_t push_word,
  input  logic              full
);
  import uclp_pkg::*;

  logic [LINE_W-1:0] line_length;
  logic [LINE_W-1:0] line_length_next;
  logic [7:0]        c;
  logic              over;

  assign c        = rx.rx_byte;
  assign rx.ready = !full;
  assign push     = rx.valid && !full;
  assign over     = (line_length >= LINE_W'(MAX_LINE));

  always_comb begin
    push_word.data   = c;
    push_word.nl     = (c == CH_NL);
    push_word.space  = (c == CH_SPACE);
    push_word.dollar = (c == CH_DOLLAR);
    push_word.digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    push_word.blank  = (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    push_word.plus   = (c == CH_PLUS);
    push_word.minus  = (c == CH_MINUS);
    push_word.first  = (line_length == '0);
    push_word.over   = over;
  end

  always_comb begin
    line_length_next = line_length;
    if (c == CH_NL) begin
      line_length_next = '0;
    end else if (!over) begin
      line_length_next = line_length + LINE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
    end else if (push) begin
      line_length <= line_length_next;
    end
  end

endmodule

/* hdl/uclp_fifo.sv */
// ----------------------------------------------------------------------------
// uclp_fifo
// Short queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module uclp_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  uclp_pkg::rx_word_t push_word,
  output logic               full,
  input  logic               pop,
  output uclp_pkg::rx_word_t pop_word,
  output logic               empty
);
  import uclp_pkg::*;

  rx_word_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_word = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/uclp_back.sv */
// ----------------------------------------------------------------------------
// uclp_back
// Token matching, number conversion and the registered result stage.
// ----------------------------------------------------------------------------
module uclp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  uclp_pkg::rx_word_t pop_word,
  output logic               pop,
  uclp_result_if.source      result
);
  import uclp_pkg::*;

  logic                 marked, marked_next;
  logic [1:0]           tok_num, tok_num_next;
  logic [TOK_LEN_W-1:0] tok_len, tok_len_next;
  logic [7:0]           tok_chars [TOK_CHARS];
  logic                 cmd, cmd_next;
  logic [1:0]           dev, dev_next;
  logic [1:0]           err, err_next;
  logic [NUM_W-1:0]     accum, accum_next;
  logic                 neg, neg_next;
  num_phase_t           phase, phase_next;
  logic                 char_wr;

  logic                 res_valid;
  logic                 res_load;
  logic [1:0]           res_status;
  logic                 res_command;
  logic [1:0]           res_device;
  logic                 res_present;
  logic [NUM_W-1:0]     res_value;

  rx_word_t             w;
  logic                 kw_get, kw_put, kw_temp, kw_ph, kw_led;
  logic                 et_cmd;
  logic [1:0]           et_dev, et_err, et_num;
  logic                 f_cmd;
  logic [1:0]           f_dev, f_err, f_num;
  logic [ACC_W-1:0]     acc_prod;
  logic [NUM_W-1:0]     acc_digit;
  logic                 line_on;

  assign w   = pop_word;
  assign pop = !empty && (!w.nl || !res_valid || result.ready);

  // keyword compare on the buffered token
  always_comb begin
    kw_get  = (tok_len == 3'd4) && (tok_chars[0] == KW_GET[31:24]) &&
              (tok_chars[1] == KW_GET[23:16]) && (tok_chars[2] == KW_GET[15:8]) &&
              (tok_chars[3] == KW_GET[7:0]);
    kw_put  = (tok_len == 3'd4) && (tok_chars[0] == KW_PUT[31:24]) &&
              (tok_chars[1] == KW_PUT[23:16]) && (tok_chars[2] == KW_PUT[15:8]) &&
              (tok_chars[3] == KW_PUT[7:0]);
    kw_temp = (tok_len == 3'd4) && (tok_chars[0] == KW_TEMP[31:24]) &&
              (tok_chars[1] == KW_TEMP[23:16]) && (tok_chars[2] == KW_TEMP[15:8]) &&
              (tok_chars[3] == KW_TEMP[7:0]);
    kw_ph   = (tok_len == 3'd2) && (tok_chars[0] == KW_PH[15:8]) &&
              (tok_chars[1] == KW_PH[7:0]);
    kw_led  = (tok_len == 3'd3) && (tok_chars[0] == KW_LED[23:16]) &&
              (tok_chars[1] == KW_LED[15:8]) && (tok_chars[2] == KW_LED[7:0]);
  end

  // effect of closing the current token
  always_comb begin
    et_cmd = cmd;
    et_dev = dev;
    et_err = err;
    if (tok_num == TOK_CMD) begin
      if (kw_get) begin
        et_cmd = CMD_GET;
      end else if (kw_put) begin
        et_cmd = CMD_PUT;
      end else if (err == ST_OK) begin
        et_err = ST_BAD_CMD;
      end
    end else if (tok_num == TOK_DEV) begin
      if (kw_temp) begin
        et_dev = DEV_TEMP;
      end else if (kw_ph) begin
        et_dev = DEV_PH;
      end else if (kw_led) begin
        et_dev = DEV_LED;
      end else if (err == ST_OK) begin
        et_err = ST_BAD_DEV;
      end
    end
    et_num = (tok_num == TOK_PAST) ? tok_num : tok_num + 2'd1;
  end

  // end of line: close a pending token, then flag missing tokens
  always_comb begin
    f_cmd = cmd;
    f_dev = dev;
    f_err = err;
    f_num = tok_num;
    if (tok_len != '0) begin
      f_cmd = et_cmd;
      f_dev = et_dev;
      f_err = et_err;
      f_num = et_num;
    end
    if (f_err == ST_OK) begin
      if (f_num == TOK_CMD) begin
        f_err = ST_BAD_CMD;
      end else if (f_num == TOK_DEV) begin
        f_err = ST_BAD_DEV;
      end
    end
  end

  // accum * 10 + digit, saturated at 2^31
  always_comb begin
    acc_prod = ({4'b0, accum} << 3) + ({4'b0, accum} << 1) +
               ACC_W'(w.data[3:0]);
    if (acc_prod > ACC_W'(NUM_SAT)) begin
      acc_digit = NUM_SAT;
    end else begin
      acc_digit = acc_prod[NUM_W-1:0];
    end
  end

  assign line_on = w.first ? w.dollar : marked;

  // number phase and accumulator
  always_comb begin
    phase_next = phase;
    neg_next   = neg;
    accum_next = accum;
    if (!w.nl && !w.over && line_on && !w.space && tok_num == TOK_PARAM) begin
      case (phase)
        NUM_IDLE: begin
          if (w.blank) begin
            phase_next = NUM_IDLE;
          end else if (w.plus) begin
            phase_next = NUM_DIGITS;
          end else if (w.minus) begin
            phase_next = NUM_DIGITS;
            neg_next   = 1'b1;
          end else if (w.digit) begin
            phase_next = NUM_DIGITS;
            accum_next = acc_digit;
          end else begin
            phase_next = NUM_STOP;
          end
        end
        NUM_DIGITS: begin
          if (w.digit) begin
            accum_next = acc_digit;
          end else begin
            phase_next = NUM_STOP;
          end
        end
        default: phase_next = phase;
      endcase
    end
    if (w.nl) begin
      phase_next = NUM_IDLE;
      neg_next   = 1'b0;
      accum_next = '0;
    end
  end

  // token and line state
  always_comb begin
    marked_next  = marked;
    tok_num_next = tok_num;
    tok_len_next = tok_len;
    cmd_next     = cmd;
    dev_next     = dev;
    err_next     = err;
    char_wr      = 1'b0;
    if (w.nl) begin
      marked_next  = 1'b0;
      tok_num_next = TOK_CMD;
      tok_len_next = '0;
      cmd_next     = CMD_GET;
      dev_next     = DEV_TEMP;
      err_next     = ST_OK;
    end else if (w.over) begin
      err_next = ST_OVERFLOW;
    end else begin
      marked_next = line_on;
      if (line_on) begin
        if (w.space) begin
          if (tok_len != '0) begin
            cmd_next     = et_cmd;
            dev_next     = et_dev;
            err_next     = et_err;
            tok_num_next = et_num;
            tok_len_next = '0;
          end
        end else begin
          char_wr = (tok_num == TOK_CMD || tok_num == TOK_DEV) &&
                    (tok_len < TOK_LEN_W'(TOK_CHARS));
          if (tok_len != '1) begin
            tok_len_next = tok_len + TOK_LEN_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      marked  <= 1'b0;
      tok_num <= TOK_CMD;
      tok_len <= '0;
      cmd     <= CMD_GET;
      dev     <= DEV_TEMP;
      err     <= ST_OK;
      accum   <= '0;
      neg     <= 1'b0;
      phase   <= NUM_IDLE;
    end else if (pop) begin
      marked  <= marked_next;
      tok_num <= tok_num_next;
      tok_len <= tok_len_next;
      cmd     <= cmd_next;
      dev     <= dev_next;
      err     <= err_next;
      accum   <= accum_next;
      neg     <= neg_next;
      phase   <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && char_wr) begin
      tok_chars[tok_len] <= w.data;
    end
  end

  // result stage
  assign res_load = pop && w.nl && marked;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_status <= f_err;
      if (f_err == ST_OK) begin
        res_command <= f_cmd;
        res_device  <= f_dev;
        res_present <= (f_num == TOK_PAST);
        if (f_num != TOK_PAST) begin
          res_value <= '0;
        end else if (neg) begin
          res_value <= '0 - accum;
        end else if (accum > NUM_MAX) begin
          res_value <= NUM_MAX;
        end else begin
          res_value <= accum;
        end
      end else begin
        res_command <= CMD_GET;
        res_device  <= DEV_TEMP;
        res_present <= 1'b0;
        res_value   <= '0;
      end
    end
  end

  assign result.valid         = res_valid;
  assign result.status        = res_status;
  assign result.command       = res_command;
  assign result.device        = res_device;
  assign result.param_present = res_present;
  assign result.param_value   = signed'(res_value);

endmodule

/* hdl/uart_command_line_parser.sv */
// ----------------------------------------------------------------------------
// uart_command_line_parser
// Parses "$CMD DEV [number]" lines from a byte stream into one result a line.
// ----------------------------------------------------------------------------
// Channels: rx takes one received byte a word; a newline ends the line.
// result gives one word for each line whose first byte is '$': status,
// command, device and the optional saturated decimal parameter. Other lines
// give no word.
// Throughput: one byte a cycle unless result stalls. The front classifies
// a byte in the cycle it is taken, a two-entry queue holds it, and the
// back parses one byte a cycle with a single multiply-by-ten accumulate.
// Path: a taken newline goes into the queue, is popped by the back once no
// earlier result waits, then loads the result register and result.valid.
// Stall: while result waits, the back holds on the next newline only; bytes
// of the following line keep flowing until that newline, then the queue
// fills and rx.ready drops.
// Reset: rst clears line position, parse state, queue and result valid.
// ----------------------------------------------------------------------------
module uart_command_line_parser #(
  parameter int MAX_LINE = uclp_pkg::MAX_LINE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  uclp_byte_if.sink     rx,
  uclp_result_if.source result
);
  import uclp_pkg::*;

  logic     push;
  logic     full;
  logic     pop;
  logic     empty;
  rx_word_t push_word;
  rx_word_t pop_word;

  uclp_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .push      (push),
    .push_word (push_word),
    .full      (full)
  );

  uclp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (full),
    .pop       (pop),
    .pop_word  (pop_word),
    .empty     (empty)
  );

  uclp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop_word (pop_word),
    .pop      (pop),
    .result   (result)
  );

endmodule

/* tb/uclp_line_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uclp_line_checker
// Watches both channels of the command line parser and checks every result.
// Each byte taken on rx is run through a parser model of its own; a kept line
// queues the result it must give. Each result word is compared with the
// oldest queued line.
// ----------------------------------------------------------------------------
module uclp_line_checker #(
  parameter int MAX_LINE = uclp_pkg::MAX_LINE_DEF
) (
  input  logic    clk,
  input  logic    rst,
  uclp_byte_if    rx,
  uclp_result_if  result,
  output int      mismatches,
  output int      outstanding
);
  import uclp_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic        command;
    logic [1:0]  device;
    logic        present;
    logic [31:0] value;
  } line_result_t;

  // parser state of the model
  int unsigned       line_len;
  bit                line_marked;
  logic [1:0]        tok_num;
  logic [7:0]        tok_chars [TOK_CHARS];
  logic [2:0]        tok_len;
  logic              cmd_sel;
  logic [1:0]        dev_sel;
  logic [1:0]        err_code;
  logic [NUM_W-1:0]  num_mag;
  num_phase_t        num_ph;
  bit                num_neg;

  line_result_t      expected_lines [$];

  function automatic bit token_matches(input logic [31:0] kw, input int len);
    if (tok_len != len) return 1'b0;
    for (int i = 0; i < len; i++) begin
      if (tok_chars[i] != kw[8*(len-1-i) +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_line();
    line_len    = 0;
    line_marked = 1'b0;
    tok_num     = TOK_CMD;
    for (int i = 0; i < TOK_CHARS; i++) tok_chars[i] = 8'd0;
    tok_len     = '0;
    cmd_sel     = CMD_GET;
    dev_sel     = DEV_TEMP;
    err_code    = ST_OK;
    num_mag     = '0;
    num_ph      = NUM_IDLE;
    num_neg     = 1'b0;
  endtask

  // keep the first error of a line
  task automatic flag_error(input logic [1:0] code);
    if (err_code == ST_OK) err_code = code;
  endtask

  task automatic close_token();
    if (tok_num == TOK_CMD) begin
      if (token_matches(KW_GET, 4)) cmd_sel = CMD_GET;
      else if (token_matches(KW_PUT, 4)) cmd_sel = CMD_PUT;
      else flag_error(ST_BAD_CMD);
    end else if (tok_num == TOK_DEV) begin
      if (token_matches(KW_TEMP, 4)) dev_sel = DEV_TEMP;
      else if (token_matches({16'd0, KW_PH}, 2)) dev_sel = DEV_PH;
      else if (token_matches({8'd0, KW_LED}, 3)) dev_sel = DEV_LED;
      else flag_error(ST_BAD_DEV);
    end
    if (tok_num != TOK_PAST) tok_num = tok_num + 2'd1;
    tok_len = '0;
  endtask

  task automatic add_digit(input logic [7:0] c);
    logic [63:0] t;
    t = {32'd0, num_mag} * 64'd10 + {56'd0, c - CH_ZERO};
    if (t > {32'd0, NUM_SAT}) t = {32'd0, NUM_SAT};
    num_mag = t[31:0];
  endtask

  task automatic number_step(input logic [7:0] c);
    bit digit;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    case (num_ph)
      NUM_IDLE: begin
        if (c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR) return;
        if (c == CH_PLUS) begin
          num_ph = NUM_DIGITS;
        end else if (c == CH_MINUS) begin
          num_ph  = NUM_DIGITS;
          num_neg = 1'b1;
        end else if (digit) begin
          add_digit(c);
          num_ph = NUM_DIGITS;
        end else begin
          num_ph = NUM_STOP;
        end
      end
      NUM_DIGITS: begin
        if (digit) add_digit(c);
        else num_ph = NUM_STOP;
      end
      default: ;
    endcase
  endtask

  task automatic predict_byte(input logic [7:0] c);
    line_result_t want;
    bit           present;
    if (c == CH_NL) begin
      if (line_marked) begin
        if (tok_len != 0) close_token();
        present = (tok_num == TOK_PAST);
        if (tok_num == TOK_CMD) flag_error(ST_BAD_CMD);
        else if (tok_num == TOK_DEV) flag_error(ST_BAD_DEV);
        want = '0;
        want.status = err_code;
        if (err_code == ST_OK) begin
          want.command = cmd_sel;
          want.device  = dev_sel;
          want.present = present;
          if (present) begin
            if (num_neg) want.value = 32'd0 - num_mag;
            else if (num_mag > NUM_MAX) want.value = NUM_MAX;
            else want.value = num_mag;
          end
        end
        expected_lines.push_back(want);
      end
      clear_line();
      return;
    end
    // past the line limit: flag, do not parse
    if (line_len >= MAX_LINE) begin
      err_code = ST_OVERFLOW;
      return;
    end
    if (line_len == 0) line_marked = (c == CH_DOLLAR);
    line_len++;
    if (!line_marked) return;
    if (c == CH_SPACE) begin
      if (tok_len != 0) close_token();
      return;
    end
    if (tok_num == TOK_PARAM) number_step(c);
    if (tok_num < TOK_PARAM && tok_len < TOK_CHARS) tok_chars[tok_len] = c;
    if (tok_len != 3'd7) tok_len = tok_len + 3'd1;
  endtask

  always @(posedge clk) begin
    line_result_t got;
    line_result_t want;
    if (rst) begin
      clear_line();
    end else begin
      if (rx.valid && rx.ready) predict_byte(rx.rx_byte);
      if (result.valid && result.ready) begin
        got.status  = result.status;
        got.command = result.command;
        got.device  = result.device;
        got.present = result.param_present;
        got.value   = result.param_value;
        if (expected_lines.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: word with no line pending: st %0d cmd %0d dev %0d",
                     $realtime, got.status, got.command, got.device);
          mismatches++;
        end else begin
          want = expected_lines.pop_front();
          if (got.status !== want.status || got.command !== want.command ||
              got.device !== want.device || got.present !== want.present ||
              got.value !== want.value) begin
            if (mismatches < 10)
              $display("%0t: exp %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                       $realtime, want.status, want.command, want.device, want.present,
                       $signed(want.value), got.status, got.command, got.device,
                       got.present, $signed(got.value));
            mismatches++;
          end
        end
      end
    end
    outstanding <= expected_lines.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Byte stream stimulus for the command line parser.
// Sends a directed set of lines (keywords, errors, number edge cases, line
// limit), then random lines, mostly well-formed with random content, under
// three idle patterns and one long result hold-off. The line checker does
// all prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
  import uclp_pkg::*;

  localparam int MAX_LINE     = MAX_LINE_DEF;
  localparam int RANDOM_BYTES = 1240;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  uclp_byte_if   rx_ch ();
  uclp_result_if res_ch ();

  int mismatches;
  int outstanding;

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  bit hold_req      = 1'b0;
  int hold_left;
  bit hold_done;
  int cycle_count   = 0;
  int random_bytes  = 0;

  logic [7:0] line_buf [$];

  uart_command_line_parser #(.MAX_LINE(MAX_LINE)) dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch)
  );

  uclp_line_checker #(.MAX_LINE(MAX_LINE)) line_check (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx_ch),
    .result      (res_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      res_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
  endtask

  task automatic put_byte(input logic [7:0] b);
    line_buf.push_back(b);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic put_spaces(input int n);
    repeat (n) line_buf.push_back(CH_SPACE);
  endtask

  // append the newline and send the whole line
  task automatic send_line();
    line_buf.push_back(CH_NL);
    random_bytes += line_buf.size();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    line_buf.delete();
  endtask

  function automatic logic [7:0] any_text_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == CH_NL);
    return v;
  endfunction

  // keyword, sometimes damaged by one byte
  task automatic put_keyword(input string s, input bit damage);
    int pos;
    if (!damage) begin
      put_text(s);
      return;
    end
    pos = $urandom_range(0, s.len() - 1);
    case ($urandom_range(0, 2))
      0: put_text(s.substr(0, s.len() - 2));
      1: begin
        put_text(s);
        put_byte(any_text_byte());
      end
      default: begin
        for (int i = 0; i < s.len(); i++) put_byte(i == pos ? any_text_byte() : s[i]);
      end
    endcase
  endtask

  task automatic put_number();
    logic [7:0] blanks [4];
    blanks = '{CH_TAB, CH_VT, CH_FF, CH_CR};
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) put_byte(blanks[$urandom_range(0, 3)]);
    end
    case ($urandom_range(0, 4))
      0: put_byte(CH_PLUS);
      1, 2: put_byte(CH_MINUS);
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 5))
        0: put_text("2147483647");
        1: put_text("2147483648");
        2: put_text("2147483649");
        3: put_text("4294967295");
        4: put_text("99999999999");
        default: put_text("0000000000002147483647");
      endcase
    end else begin
      repeat ($urandom_range(0, 12)) put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 6) == 0) put_byte(any_text_byte());
  endtask

  task automatic random_line();
    int kind;
    int r;
    logic [7:0] first;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      // not kept: first byte is not the marker
      do first = any_text_byte(); while (first == CH_DOLLAR);
      put_byte(first);
      repeat ($urandom_range(0, 20)) put_byte(any_text_byte());
    end else if (kind < 11) begin
      // around the line limit
      put_byte($urandom_range(0, 3) != 0 ? CH_DOLLAR : 8'h23);
      put_text("PUT LED ");
      repeat ($urandom_range(45, 70))
        put_byte($urandom_range(0, 4) == 0 ? CH_SPACE : 8'(CH_ZERO + $urandom_range(0, 9)));
    end else if (kind < 17) begin
      put_byte(CH_DOLLAR);
      repeat ($urandom_range(0, 14)) put_byte(any_text_byte());
    end else begin
      put_keyword($urandom_range(0, 1) ? "$GET" : "$PUT", $urandom_range(0, 9) == 0);
      r = $urandom_range(0, 9);
      if (r != 0) begin
        put_spaces($urandom_range(1, 3));
        case ($urandom_range(0, 2))
          0: put_keyword("TEMP", r == 1);
          1: put_keyword("PH", r == 1);
          default: put_keyword("LED", r == 1);
        endcase
        if ($urandom_range(0, 9) < 7) begin
          put_spaces($urandom_range(1, 3));
          put_number();
          if ($urandom_range(0, 4) == 0) begin
            put_spaces($urandom_range(1, 2));
            repeat ($urandom_range(1, 6)) put_byte(any_text_byte());
          end
        end
      end
      if ($urandom_range(0, 3) == 0) put_spaces($urandom_range(1, 2));
    end
    send_line();
  endtask

  initial begin
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    put_text("$GET TEMP");                      send_line();
    put_text("$PUT PH 42");                     send_line();
    put_text("$GET LED -2147483648");           send_line();
    put_text("$PUT TEMP 2147483647");           send_line();
    put_text("$PUT LED 99999999999");           send_line();
    put_text("$GET PH -99999999999");           send_line();
    put_text("$GET   TEMP   +17  junk more");   send_line();
    put_text("$PUT TEMP 1 2 3");                send_line();
    put_text("$SET TEMP 1");                    send_line();
    put_text("$GET FOO 1");                     send_line();
    put_text("$FOO BAR");                       send_line();
    put_text("$PUT");                           send_line();
    put_text("$PUT ");                          send_line();
    put_text("$");                              send_line();
    send_line();
    put_text("hello $GET TEMP");                send_line();
    // leading blanks before the sign, conversion stops at the letter
    put_text("$GET PH ");
    put_byte(CH_TAB); put_byte(CH_CR); put_byte(CH_VT); put_byte(CH_FF);
    put_text("-5x9");                           send_line();
    put_text("$GET PH abc");                    send_line();
    put_text("$GET PH +-3");                    send_line();
    put_text("$GETXYZ123 TEMP");                send_line();
    put_text("$GET"); put_byte(8'h00); put_text(" PH");  send_line();
    put_text("$PUT LED 7"); put_byte(8'hff);    send_line();
    put_text("$GET PH"); put_byte(CH_CR);       send_line();
    // exactly at the limit, then one byte past it
    put_text("$GET PH 9"); put_spaces(MAX_LINE - 9);     send_line();
    put_text("$GET PH 9"); put_spaces(MAX_LINE - 8);     send_line();
    put_byte(8'h78); repeat (80) put_byte(8'h61);        send_line();

    random_bytes = 0;
    for (int stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin src_idle_pct = 30; sink_idle_pct = 78; end
        1: begin src_idle_pct = 78; sink_idle_pct = 30; end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
          hold_req     <= 1'b1;
        end
      endcase
      while (random_bytes < RANDOM_BYTES * (stage + 1) / 3) random_line();
    end
    rx_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/uclp_pkg.sv
hdl/uclp_if.sv
hdl/uclp_front.sv
hdl/uclp_fifo.sv
hdl/uclp_back.sv
hdl/uart_command_line_parser.sv
tb/uclp_line_checker.sv
tb/testbench.sv
